@@ rtl/core/gspi_pkg.sv @@
// shared constants, widths and types of the wheel speed controller
`default_nettype none

package gspi_pkg;

    localparam int WINDOW = 20;
    localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    localparam int PERIOD_W = 12;
    localparam int GAIN_W = 8;
    localparam int FACTOR_W = 12;
    localparam int WANT_W = 8;
    localparam int EDGE_W = 10;
    localparam int MEAS_W = 12;
    localparam int ERR_W = 13;
    localparam int SUM_W = 18;
    localparam int EFFORT_W = 12;
    localparam int KP_W = 11;
    localparam int KI_W = 9;

    localparam int MCAND_W = 17;
    localparam int MPLIER_W = 12;
    localparam int PROD_W = MCAND_W + MPLIER_W;
    localparam int DIGIT_W = 2;
    localparam int MUL_STEPS = MPLIER_W / DIGIT_W;
    localparam int STEP_W = $clog2(MUL_STEPS);

    localparam int Q_SHIFT = 8;
    localparam int RND_W = PROD_W + 1 - Q_SHIFT;
    localparam int TERM_W = RND_W;
    localparam int X_W = TERM_W;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KP_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_BASE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FACTOR = 2'd3;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 12'd1250;
    localparam logic [GAIN_W-1:0] KP_RST = 8'd13;
    localparam logic [GAIN_W-1:0] KI_RST = 8'd18;
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 12'd853;
    localparam logic [EFFORT_W-1:0] EFFORT_RST = 12'd650;

    localparam logic [MEAS_W-1:0] MEAS_MAX = 12'd4095;
    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(128);

    typedef struct packed {
        logic                start;
        logic [MCAND_W-1:0]  mcand;
        logic [MPLIER_W-1:0] mplier;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] product;
    } t_mul_rsp;

endpackage

`default_nettype wire

@@ rtl/core/gspi_smul.sv @@
// digit serial shift-add multiplier, two multiplier bits per cycle
`default_nettype none

module gspi_smul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gspi_pkg::t_mul_req  i_req,
    output gspi_pkg::t_mul_rsp  o_rsp
);
    import gspi_pkg::*;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MUL_STEPS - 1);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [PROD_W-1:0]   r_mc;
    logic [MPLIER_W-1:0] r_mp;
    logic [PROD_W-1:0]   r_acc;
    logic [PROD_W-1:0]   w_pp;

    always_comb begin
        w_pp = '0;
        for (int k = 0; k < DIGIT_W; k++) begin
            if (r_mp[k]) begin
                w_pp = w_pp + (r_mc << k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mc  <= PROD_W'(i_req.mcand);
            r_mp  <= i_req.mplier;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_pp;
            r_mc  <= r_mc << DIGIT_W;
            r_mp  <= r_mp >> DIGIT_W;
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

`default_nettype wire

@@ rtl/core/gain_scheduled_pi_wheel_speed.sv @@
// top level of the gain scheduled pi wheel speed controller
//
// channel   direction  handshake                 payload
// input     in         i_valid / o_ready         i_wanted_speed, i_edge_count
// result    out        o_valid / i_ready         o_duty_a, o_duty_b,
//                                                o_measured_speed, o_speed_error
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// each word runs through two passes of the 2-bit serial multipliers (6 steps each)
// plus error, rounding and clamp steps before its result is registered
// the next word is taken only once the result is in the output register
// a stalled result holds in the output register while the next word computes
// synchronous active low reset; the error window clears at once, no sweep
// config writes are taken every cycle
`default_nettype none

module gain_scheduled_pi_wheel_speed (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [gspi_pkg::WANT_W-1:0]   i_wanted_speed,
    input  logic        [gspi_pkg::EDGE_W-1:0]   i_edge_count,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic        [gspi_pkg::PERIOD_W-1:0] o_duty_a,
    output logic        [gspi_pkg::PERIOD_W-1:0] o_duty_b,
    output logic        [gspi_pkg::MEAS_W-1:0]   o_measured_speed,
    output logic signed [gspi_pkg::ERR_W-1:0]    o_speed_error,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic        [gspi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [gspi_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gspi_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MEAS = 3'd1;
    localparam logic [2:0] S_ERR  = 3'd2;
    localparam logic [2:0] S_PI   = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

    logic [2:0]            r_state;
    logic [PERIOD_W-1:0]   r_period;
    logic [GAIN_W-1:0]     r_kp_base;
    logic [GAIN_W-1:0]     r_ki_base;
    logic [FACTOR_W-1:0]   r_factor;

    logic signed [ERR_W-1:0] r_ring [WINDOW];
    logic [POS_W-1:0]        r_pos;
    logic signed [SUM_W-1:0] r_sum;
    logic [EFFORT_W-1:0]     r_effort;

    logic [WANT_W-1:0]        r_mag;
    logic                     r_backward;
    logic [MEAS_W-1:0]        r_meas;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [TERM_W-1:0] r_pterm;
    logic signed [TERM_W-1:0] r_iterm;

    logic                     r_out_valid;
    logic [PERIOD_W-1:0]      r_duty_a;
    logic [PERIOD_W-1:0]      r_duty_b;
    logic [MEAS_W-1:0]        r_meas_out;
    logic signed [ERR_W-1:0]  r_err_out;

    t_mul_req w_req_a;
    t_mul_req w_req_b;
    t_mul_rsp w_rsp_a;
    t_mul_rsp w_rsp_b;

    logic                     w_accept;
    logic [PROD_W:0]          w_rnd_a;
    logic [PROD_W:0]          w_rnd_b;
    logic [RND_W-1:0]         w_meas_full;
    logic [MEAS_W-1:0]        w_meas;
    logic signed [ERR_W-1:0]  w_err;
    logic signed [SUM_W-1:0]  w_sum_new;
    logic [ERR_W-1:0]         w_abs_err;
    logic [SUM_W-1:0]         w_abs_sum;
    logic [KP_W-1:0]          w_kp;
    logic [KI_W-1:0]          w_ki;
    logic [KP_W-1:0]          w_kp_b;
    logic signed [X_W-1:0]    w_x;
    logic [PERIOD_W-1:0]      w_reflect;
    logic                     w_out_free;
    logic                     w_pi_done;

    assign w_accept   = i_valid && o_ready;
    assign o_ready    = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_pi_done  = w_rsp_a.done && w_rsp_b.done;

    // measured speed, rounded and saturated
    assign w_rnd_a     = {1'b0, w_rsp_a.product} + ROUND_HALF;
    assign w_rnd_b     = {1'b0, w_rsp_b.product} + ROUND_HALF;
    assign w_meas_full = w_rnd_a[PROD_W:Q_SHIFT];
    assign w_meas      = (|w_meas_full[RND_W-1:MEAS_W]) ? MEAS_MAX : w_meas_full[MEAS_W-1:0];
    assign w_err       = $signed(ERR_W'(r_mag)) - $signed(ERR_W'(w_meas));

    // window sum and gain schedule
    assign w_sum_new = r_sum - SUM_W'(r_ring[r_pos]) + SUM_W'(r_err);
    assign w_abs_err = r_err[ERR_W-1] ? ERR_W'(-r_err) : r_err;
    assign w_abs_sum = w_sum_new[SUM_W-1] ? SUM_W'(-w_sum_new) : w_sum_new;
    assign w_kp_b    = KP_W'(r_kp_base);

    always_comb begin
        w_ki = KI_W'(r_ki_base);
        priority if (w_abs_err <= ERR_W'(2)) begin
            w_kp = (w_kp_b << 2) + w_kp_b;
        end else if (w_abs_err <= ERR_W'(4)) begin
            w_kp = w_kp_b << 2;
        end else if (w_abs_err <= ERR_W'(6)) begin
            w_kp = (w_kp_b << 1) + w_kp_b;
        end else if (w_abs_err <= ERR_W'(8)) begin
            w_kp = w_kp_b << 1;
        end else begin
            w_kp = (w_kp_b << 1) + w_kp_b;
            w_ki = KI_W'(r_ki_base) << 1;
        end
    end

    always_comb begin
        w_req_a = '0;
        w_req_b = '0;
        if (r_state == S_IDLE) begin
            w_req_a.start  = w_accept;
            w_req_a.mcand  = MCAND_W'(r_factor);
            w_req_a.mplier = MPLIER_W'(i_edge_count);
        end else if (r_state == S_ERR) begin
            w_req_a.start  = 1'b1;
            w_req_a.mcand  = MCAND_W'(w_abs_err);
            w_req_a.mplier = MPLIER_W'(w_kp);
            w_req_b.start  = 1'b1;
            w_req_b.mcand  = w_abs_sum[MCAND_W-1:0];
            w_req_b.mplier = MPLIER_W'(w_ki);
        end
    end

    gspi_smul u_mul_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req_a),
        .o_rsp   (w_rsp_a)
    );

    gspi_smul u_mul_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req_b),
        .o_rsp   (w_rsp_b)
    );

    assign w_x = X_W'($signed({1'b0, r_effort})) + r_pterm + r_iterm;
    assign w_reflect = r_period - r_effort;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= PERIOD_RST;
            r_kp_base <= KP_RST;
            r_ki_base <= KI_RST;
            r_factor  <= FACTOR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PWM_PERIOD:   r_period  <= i_cfg_data[PERIOD_W-1:0];
                CFG_KP_BASE:      r_kp_base <= i_cfg_data[GAIN_W-1:0];
                CFG_KI_BASE:      r_ki_base <= i_cfg_data[GAIN_W-1:0];
                CFG_SPEED_FACTOR: r_factor  <= i_cfg_data[FACTOR_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_sum       <= '0;
            r_effort    <= EFFORT_RST;
            r_out_valid <= 1'b0;
            for (int k = 0; k < WINDOW; k++) begin
                r_ring[k] <= '0;
            end
        end else begin
            // a new word loads, or a held word stays until taken
            r_out_valid <= (r_state == S_OUT && w_out_free) || (r_out_valid && !i_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_MEAS;
                    end
                end
                S_MEAS: begin
                    if (w_rsp_a.done) begin
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_sum         <= w_sum_new;
                    r_ring[r_pos] <= r_err;
                    r_pos         <= (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
                    r_state       <= S_PI;
                end
                S_PI: begin
                    if (w_pi_done) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    priority if (w_x >= $signed(X_W'(r_period))) begin
                        r_effort <= r_period;
                    end else if (w_x <= $signed(X_W'(0))) begin
                        r_effort <= '0;
                    end else begin
                        r_effort <= w_x[EFFORT_W-1:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath words
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_backward <= i_wanted_speed[WANT_W-1];
            r_mag      <= i_wanted_speed[WANT_W-1] ? WANT_W'(-i_wanted_speed)
                                                   : WANT_W'(i_wanted_speed);
        end
        if (r_state == S_MEAS && w_rsp_a.done) begin
            r_meas <= w_meas;
            r_err  <= w_err;
        end
        if (r_state == S_PI && w_pi_done) begin
            r_pterm <= r_err[ERR_W-1] ? -$signed(w_rnd_a[PROD_W:Q_SHIFT])
                                      : $signed(w_rnd_a[PROD_W:Q_SHIFT]);
            r_iterm <= r_sum[SUM_W-1] ? -$signed(w_rnd_b[PROD_W:Q_SHIFT])
                                      : $signed(w_rnd_b[PROD_W:Q_SHIFT]);
        end
        if (r_state == S_OUT && w_out_free) begin
            r_duty_a   <= r_backward ? w_reflect : r_period;
            r_duty_b   <= r_backward ? r_period : w_reflect;
            r_meas_out <= r_meas;
            r_err_out  <= r_err;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_duty_a         = r_duty_a;
    assign o_duty_b         = r_duty_b;
    assign o_measured_speed = r_meas_out;
    assign o_speed_error    = r_err_out;

endmodule

`default_nettype wire

@@ rtl/core/gspi_checker.sv @@
// port level checks of the wheel speed controller and their bind
`default_nettype none

module gspi_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 o_ready,
    input  logic                                 o_valid,
    input  logic                                 i_ready,
    input  logic        [gspi_pkg::PERIOD_W-1:0] o_duty_a,
    input  logic        [gspi_pkg::PERIOD_W-1:0] o_duty_b,
    input  logic        [gspi_pkg::MEAS_W-1:0]   o_measured_speed,
    input  logic signed [gspi_pkg::ERR_W-1:0]    o_speed_error
);
    import gspi_pkg::*;

    logic signed [ERR_W:0] w_mag;

    // measured speed plus error gives back the wanted magnitude
    assign w_mag = $signed({2'b00, o_measured_speed}) + (ERR_W + 1)'(o_speed_error);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_duty_a) && $stable(o_duty_b)
            && $stable(o_measured_speed) && $stable(o_speed_error)))
        else $error("result word changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while a word is in progress");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (w_mag >= 0 && w_mag <= 128))
        else $error("speed error does not match measured speed");

    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_valid) |-> $past(i_ready))
        else $error("result word dropped without handshake");

endmodule

bind gain_scheduled_pi_wheel_speed gspi_checker u_gspi_checker (.*);

`default_nettype wire

@@ bench/gain_scheduled_pi_wheel_speed_tb.sv @@
// self-checking testbench for the gain scheduled pi wheel speed controller
`timescale 1ns / 1ps

module gain_scheduled_pi_wheel_speed_tb;
    import gspi_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 10;
    localparam int RANDOM_PER_PHASE = 118;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic signed [WANT_W-1:0] want;
        logic        [EDGE_W-1:0] edges;
    } tick_in_t;

    typedef struct {
        logic        [PERIOD_W-1:0] duty_a;
        logic        [PERIOD_W-1:0] duty_b;
        logic        [MEAS_W-1:0]   meas;
        logic signed [ERR_W-1:0]    err;
    } tick_out_t;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic signed [WANT_W-1:0]     i_wanted_speed = '0;
    logic        [EDGE_W-1:0]     i_edge_count = '0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic        [PERIOD_W-1:0]   o_duty_a;
    logic        [PERIOD_W-1:0]   o_duty_b;
    logic        [MEAS_W-1:0]     o_measured_speed;
    logic signed [ERR_W-1:0]      o_speed_error;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic        [CFG_IDX_W-1:0]  i_cfg_index = CFG_PWM_PERIOD;
    logic        [CFG_DATA_W-1:0] i_cfg_data = '0;

    int cfg_period = int'(PERIOD_RST);
    int cfg_kp = int'(KP_RST);
    int cfg_ki = int'(KI_RST);
    int cfg_factor = int'(FACTOR_RST);

    int err_hist [WINDOW];
    int hist_pos = 0;
    int err_sum = 0;
    int effort = int'(EFFORT_RST);

    tick_in_t  ticks_to_send [$];
    tick_out_t tick_outputs_due [$];

    int burst_left = 0;
    int gap_left = 0;
    int ticks_sent = 0;
    int outputs_checked = 0;
    int failures = 0;
    int stall_count = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int cycle_count = 0;

    gain_scheduled_pi_wheel_speed u_top (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint round_q8(input longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + 128) >>> 8;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic tick_out_t control_tick(input logic signed [WANT_W-1:0] want,
                                               input logic [EDGE_W-1:0] edges);
        tick_out_t r;
        logic backward;
        int mag, meas, err, abs_err, kp_mult, ki_mult, reflected;
        longint prod, x;
        backward = want < 0;
        mag = backward ? -int'(want) : int'(want);
        prod = (longint'(edges) * cfg_factor + 128) >>> 8;
        meas = (prod > 4095) ? 4095 : int'(prod);
        err = mag - meas;

        err_sum = err_sum - err_hist[hist_pos] + err;
        err_hist[hist_pos] = err;
        hist_pos = (hist_pos + 1) % WINDOW;

        abs_err = (err < 0) ? -err : err;
        ki_mult = 1;
        if (abs_err <= 2) kp_mult = 5;
        else if (abs_err <= 4) kp_mult = 4;
        else if (abs_err <= 6) kp_mult = 3;
        else if (abs_err <= 8) kp_mult = 2;
        else begin
            kp_mult = 3;
            ki_mult = 2;
        end

        x = effort + round_q8(longint'(err) * (cfg_kp * kp_mult))
            + round_q8(longint'(err_sum) * (cfg_ki * ki_mult));
        if (x >= cfg_period) x = cfg_period;
        if (x <= 0) x = 0;
        effort = int'(x);

        reflected = cfg_period - effort;
        r.duty_a = backward ? PERIOD_W'(reflected) : PERIOD_W'(cfg_period);
        r.duty_b = backward ? PERIOD_W'(cfg_period) : PERIOD_W'(reflected);
        r.meas = MEAS_W'(meas);
        r.err = ERR_W'(err);
        return r;
    endfunction

    task automatic queue_tick(input int want, input int edges);
        tick_in_t t;
        t.want = WANT_W'(want);
        t.edges = EDGE_W'(edges);
        ticks_to_send.push_back(t);
    endtask

    // runs around one target, mostly with edge counts close to it
    task automatic fill_random_ticks(input int count);
        int run_len, target, mag, base, edges, pick, k;
        while (count > 0) begin
            run_len = $urandom_range(5, 30);
            target = int'($urandom_range(0, 200)) - 100;
            mag = (target < 0) ? -target : target;
            for (k = 0; k < run_len && count > 0; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    base = (cfg_factor == 0) ? int'($urandom_range(0, 1023))
                                             : (mag * 256 + cfg_factor / 2) / cfg_factor;
                    edges = base + int'($urandom_range(0, 8)) - 4;
                    if (edges < 0) edges = 0;
                    if (edges > 1023) edges = 1023;
                    queue_tick(target, edges);
                end else if (pick < 85) begin
                    queue_tick(int'($urandom_range(0, 200)) - 100, $urandom_range(0, 1023));
                end else begin
                    queue_tick($urandom, $urandom);
                end
                count--;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PWM_PERIOD:   cfg_period = val & 'hFFF;
            CFG_KP_BASE:      cfg_kp = val & 'hFF;
            CFG_KI_BASE:      cfg_ki = val & 'hFF;
            CFG_SPEED_FACTOR: cfg_factor = val & 'hFFF;
        endcase
    endtask

    task automatic program_regs(input int period, input int kp, input int ki, input int factor);
        write_reg(CFG_PWM_PERIOD, period);
        write_reg(CFG_KP_BASE, kp);
        write_reg(CFG_KI_BASE, ki);
        write_reg(CFG_SPEED_FACTOR, factor);
    endtask

    task automatic wait_drained();
        while (ticks_to_send.size() != 0 || i_valid || tick_outputs_due.size() != 0)
            @(negedge i_clk);
    endtask

    // driver: bursts of words with random gaps
    always @(posedge i_clk) begin
        tick_in_t nxt;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                tick_outputs_due.push_back(control_tick(i_wanted_speed, i_edge_count));
                ticks_sent++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0 || ticks_to_send.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    i_valid <= 1'b0;
                end else begin
                    nxt = ticks_to_send.pop_front();
                    i_valid <= 1'b1;
                    i_wanted_speed <= nxt.want;
                    i_edge_count <= nxt.edges;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
                    end
                end
            end
        end
    end

    // monitor: checks each output word and stalls on a rotating pattern
    always @(posedge i_clk) begin
        tick_out_t due;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (tick_outputs_due.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected word: duty_a %0d duty_b %0d speed %0d error %0d",
                                 o_duty_a, o_duty_b, o_measured_speed, o_speed_error);
                end else begin
                    due = tick_outputs_due.pop_front();
                    outputs_checked++;
                    if (o_duty_a !== due.duty_a || o_duty_b !== due.duty_b
                            || o_measured_speed !== due.meas || o_speed_error !== due.err) begin
                        failures++;
                        if (failures <= 10)
                            $display("word %0d: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                     outputs_checked, due.duty_a, due.duty_b, due.meas,
                                     due.err, o_duty_a, o_duty_b, o_measured_speed,
                                     o_speed_error);
                    end
                end
            end
            if (stall_count == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pattern = 16'hFFFF;
                    1: stall_pattern = 16'($urandom) | 16'h1;
                    2: stall_pattern = 16'($urandom | $urandom) | 16'h1;
                    default: stall_pattern = 16'($urandom & $urandom) | 16'h1;
                endcase
                stall_count = 48;
            end
            stall_count--;
            i_ready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due",
                     cycle_count, tick_outputs_due.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int phase;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // error bands, direction, zero and -128 speed, edge count extremes
        queue_tick(0, 0);
        queue_tick(2, 0);
        queue_tick(3, 0);
        queue_tick(4, 0);
        queue_tick(5, 0);
        queue_tick(6, 0);
        queue_tick(7, 0);
        queue_tick(8, 0);
        queue_tick(9, 0);
        queue_tick(-2, 0);
        queue_tick(-9, 0);
        queue_tick(127, 0);
        queue_tick(-128, 0);
        queue_tick(100, 30);
        queue_tick(-100, 30);
        queue_tick(1, 1);
        queue_tick(0, 1023);
        queue_tick(-1, 1023);
        queue_tick(127, 1023);
        queue_tick(-128, 1023);
        queue_tick(50, 15);
        queue_tick(-50, 15);

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                wait_drained();
                case (phase)
                    1: program_regs(4095, 255, 255, 4095);
                    2: program_regs(0, 0, 0, 0);
                    3: program_regs(1, 'hFFF, 'hF01, 256);
                    4: program_regs(4095, 40, 3, 256);
                    // period dropped below the effort built up before
                    5: program_regs(100, 13, 18, 853);
                    default: program_regs(($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                                     : $urandom_range(1, 4095),
                                          $urandom_range(0, 255), $urandom_range(0, 255),
                                          $urandom_range(64, 1024));
                endcase
            end
            if (phase == 4)
                repeat (10) queue_tick(100, 0);
            fill_random_ticks(RANDOM_PER_PHASE);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        failures += tick_outputs_due.size();
        $display("%0d control ticks sent over %0d register settings, %0d output words checked",
                 ticks_sent, PHASES, outputs_checked);
        $display("%0d errors seen", failures);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/gspi_pkg.sv
rtl/core/gspi_smul.sv
rtl/core/gain_scheduled_pi_wheel_speed.sv
rtl/core/gspi_checker.sv
bench/gain_scheduled_pi_wheel_speed_tb.sv
